// ===== rtl/ua_tcp_chunk_header_check_unit_assert.svh =====
// Assertion macros shared by the chunk header check RTL.
`ifndef UA_TCP_CHUNK_HEADER_CHECK_UNIT_ASSERT_SVH
`define UA_TCP_CHUNK_HEADER_CHECK_UNIT_ASSERT_SVH

// Immediate implication: when the antecedent holds, the consequent holds in the same cycle.
`define UATCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define UATCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/uatcc_pkg.sv =====
// Types, codes and constants of the chunk header check block.
`timescale 1ns / 1ps

package uatcc_pkg;

  // Offset of the status word inside an abort chunk.
  localparam int unsigned SYM_HEADER_BYTES = 16;
  localparam logic [31:0] ABORT_MIN_SIZE   = 32'(SYM_HEADER_BYTES + 4);

  localparam logic [31:0] MIN_HEADER_SIZE  = 32'd8;
  localparam logic [31:0] MIN_SECURE_SIZE  = 32'd12;

  // Verdict codes.
  localparam logic [2:0] V_GOOD     = 3'd0;
  localparam logic [2:0] V_INTERNAL = 3'd1;
  localparam logic [2:0] V_TYPE     = 3'd2;
  localparam logic [2:0] V_LARGE    = 3'd3;
  localparam logic [2:0] V_ABORT    = 3'd4;

  // Message kind codes.
  localparam logic [2:0] K_HEL = 3'd0;
  localparam logic [2:0] K_ACK = 3'd1;
  localparam logic [2:0] K_ERR = 3'd2;
  localparam logic [2:0] K_OPN = 3'd3;
  localparam logic [2:0] K_CLO = 3'd4;
  localparam logic [2:0] K_MSG = 3'd5;

  localparam int unsigned NUM_KINDS = 6;

  // Chunk type codes.
  localparam logic [1:0] C_INTERMEDIATE = 2'd0;
  localparam logic [1:0] C_FINAL        = 2'd1;
  localparam logic [1:0] C_ABORT        = 2'd2;

  // ASCII letters seen in the header.
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_O = 8'h4F;

  // Three-letter type words, first letter in the low byte, indexed by kind code.
  localparam logic [NUM_KINDS-1:0][23:0] KIND_WORDS = {
    24'h47534D,  // MSG
    24'h4F4C43,  // CLO
    24'h4E504F,  // OPN
    24'h525245,  // ERR
    24'h4B4341,  // ACK
    24'h4C4548   // HEL
  };

  // One received chunk header.
  typedef struct packed {
    logic [31:0] buffer_length;
    logic [31:0] abort_word;
    logic [31:0] channel_word;
    logic [63:0] header_bytes;
  } hdr_t;

  // One verdict with its decoded fields.
  typedef struct packed {
    logic [31:0] abort_code;
    logic [31:0] secure_channel;
    logic [31:0] msg_size;
    logic [1:0]  chunk_code;
    logic [2:0]  kind_code;
    logic [2:0]  verdict;
  } res_t;

endpackage

// ===== rtl/uatcc_decode.sv =====
// Combinational checks and field decode for one chunk header.
`timescale 1ns / 1ps

module uatcc_decode (
  input  uatcc_pkg::hdr_t hdr,
  output uatcc_pkg::res_t res
);

  logic [23:0] type_word;
  logic [7:0]  letter;
  logic [7:0]  first;
  logic [31:0] size;
  logic [31:0] len;
  logic        found;
  logic [2:0]  kind;
  logic        chunk_ok;
  logic [1:0]  chunk;

  assign type_word = hdr.header_bytes[23:0];
  assign letter    = hdr.header_bytes[31:24];
  assign first     = hdr.header_bytes[7:0];
  assign size      = hdr.header_bytes[63:32];
  assign len       = hdr.buffer_length;

  // Match the type word against the six accepted kinds.
  always_comb begin
    found = 1'b0;
    kind  = uatcc_pkg::K_HEL;
    for (int k = 0; k < uatcc_pkg::NUM_KINDS; k++) begin
      if (!found && type_word == uatcc_pkg::KIND_WORDS[k]) begin
        found = 1'b1;
        kind  = 3'(k);
      end
    end
  end

  // Decode the chunk letter.
  always_comb begin
    chunk_ok = 1'b1;
    chunk    = uatcc_pkg::C_INTERMEDIATE;
    unique case (letter)
      uatcc_pkg::CH_C: chunk = uatcc_pkg::C_INTERMEDIATE;
      uatcc_pkg::CH_F: chunk = uatcc_pkg::C_FINAL;
      uatcc_pkg::CH_A: chunk = uatcc_pkg::C_ABORT;
      default:         chunk_ok = 1'b0;
    endcase
  end

  // Checks in order; each field is filled only once its check is reached.
  always_comb begin
    res = '0;
    priority if (len < uatcc_pkg::MIN_HEADER_SIZE) begin
      res.verdict = uatcc_pkg::V_INTERNAL;
    end else if (!found) begin
      res.verdict = uatcc_pkg::V_TYPE;
    end else if (!chunk_ok) begin
      res.kind_code = kind;
      res.verdict   = uatcc_pkg::V_TYPE;
    end else begin
      res.kind_code  = kind;
      res.chunk_code = chunk;
      res.msg_size   = size;
      priority if (size < uatcc_pkg::MIN_HEADER_SIZE) begin
        res.verdict = uatcc_pkg::V_INTERNAL;
      end else if (size > len) begin
        res.verdict = uatcc_pkg::V_LARGE;
      end else if (chunk == uatcc_pkg::C_INTERMEDIATE && first != uatcc_pkg::CH_M) begin
        // A continuation chunk only exists inside a MSG message.
        res.verdict = uatcc_pkg::V_INTERNAL;
      end else if (kind <= uatcc_pkg::K_ERR) begin
        res.verdict = uatcc_pkg::V_GOOD;
      end else if (len < uatcc_pkg::MIN_SECURE_SIZE || size < uatcc_pkg::MIN_SECURE_SIZE) begin
        res.verdict = uatcc_pkg::V_INTERNAL;
      end else begin
        res.secure_channel = hdr.channel_word;
        if (chunk == uatcc_pkg::C_ABORT) begin
          priority if (first == uatcc_pkg::CH_O) begin
            res.verdict = uatcc_pkg::V_INTERNAL;
          end else if (size < uatcc_pkg::ABORT_MIN_SIZE) begin
            res.verdict = uatcc_pkg::V_INTERNAL;
          end else if (hdr.abort_word == '0) begin
            res.verdict = uatcc_pkg::V_INTERNAL;
          end else begin
            res.verdict    = uatcc_pkg::V_ABORT;
            res.abort_code = hdr.abort_word;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/ua_tcp_chunk_header_check_unit.sv =====
// Top level of the chunk header check: input register, decode, result register.
//
//  Channel | Dir | Bits | Beat contents
//  s_*     | in  | 160  | one chunk header to check
//  m_*     | out | 104  | one verdict with decoded fields
//
// A beat accepted on s_* is decoded from the input register and shows on m_*
// from the result register; one beat is accepted every cycle while m_* is not stalled.
// The decode between the two registers is a bank of compares.
// rst clears both valid flags; payload registers are not reset.
// A stall on m_tready holds the result; the input register still fills, so
// s_tready drops only when both stages are full.
`timescale 1ns / 1ps
`include "ua_tcp_chunk_header_check_unit_assert.svh"

module ua_tcp_chunk_header_check_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // header_bytes[63:0], channel_word[95:64], abort_word[127:96], buffer_length[159:128]
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // verdict[2:0], kind_code[5:3], chunk_code[7:6], msg_size[39:8],
  // secure_channel[71:40], abort_code[103:72]
  output logic [103:0] m_tdata
);

  uatcc_pkg::hdr_t hdr;
  logic            hdr_valid;
  uatcc_pkg::res_t dec;
  uatcc_pkg::res_t res;
  logic            res_valid;
  logic            adv_res;
  logic            adv_hdr;

  // Each stage moves when it is empty or the stage after it moves.
  assign adv_res  = !res_valid || m_tready;
  assign adv_hdr  = !hdr_valid || adv_res;
  assign s_tready = adv_hdr;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (adv_hdr) begin
      hdr_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_hdr && s_tvalid) begin
      hdr <= uatcc_pkg::hdr_t'(s_tdata);
    end
  end

  uatcc_decode u_decode (
    .hdr (hdr),
    .res (dec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv_res) begin
      res_valid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_res && hdr_valid) begin
      res <= dec;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = res;

  // An abort status is reported exactly with the aborted verdict.
  `UATCC_ASSERT_SAME(a_abort_code, res_valid, ((res.verdict == uatcc_pkg::V_ABORT) == (res.abort_code != '0)), "abort code does not match verdict")
  // Hello, acknowledge and error never carry a channel id.
  `UATCC_ASSERT_SAME(a_no_channel, res_valid && res.kind_code <= uatcc_pkg::K_ERR, res.secure_channel == '0, "channel id set for unsecured kind")
  // A decoded header moving on always lands in the result register.
  `UATCC_ASSERT_NEXT(a_advance, hdr_valid && adv_res, res_valid, "decoded beat lost")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the chunk header check unit: directed and random headers.
`timescale 1ns / 1ps

module tb_top;
  import uatcc_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // header_bytes, channel_word, abort_word, buffer_length
  logic [159:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // verdict, kind_code, chunk_code, msg_size, secure_channel, abort_code
  logic [103:0] m_tdata;

  // Verdicts predicted for accepted headers, oldest first.
  res_t pending_verdicts[$];
  int   error_count = 0;
  // When set, that side runs without idle cycles.
  bit   src_no_gaps = 1'b0;
  bit   sink_no_stalls = 1'b0;

  ua_tcp_chunk_header_check_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("ua_tcp_chunk_header_check_unit: mismatch");
    $finish;
  end

  // Expected verdict and decoded fields for one chunk header.
  function automatic res_t predict_verdict(hdr_t h);
    res_t        r;
    logic [23:0] type_word;
    logic [7:0]  letter;
    logic [7:0]  first_letter;
    bit          found;
    r = '0;
    r.verdict = V_GOOD;
    if (h.buffer_length < MIN_HEADER_SIZE) begin
      r.verdict = V_INTERNAL;
      return r;
    end
    type_word = h.header_bytes[23:0];
    letter = h.header_bytes[31:24];
    first_letter = h.header_bytes[7:0];
    found = 1'b0;
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (!found && type_word == KIND_WORDS[k]) begin
        r.kind_code = 3'(k);
        found = 1'b1;
      end
    end
    if (!found) begin
      r.verdict = V_TYPE;
      return r;
    end
    case (letter)
      CH_C: r.chunk_code = C_INTERMEDIATE;
      CH_F: r.chunk_code = C_FINAL;
      CH_A: r.chunk_code = C_ABORT;
      default: begin
        r.verdict = V_TYPE;
        return r;
      end
    endcase
    r.msg_size = h.header_bytes[63:32];
    if (r.msg_size < MIN_HEADER_SIZE) begin
      r.verdict = V_INTERNAL;
      return r;
    end
    if (r.msg_size > h.buffer_length) begin
      r.verdict = V_LARGE;
      return r;
    end
    // A continuation chunk only exists inside a MSG message.
    if (r.chunk_code == C_INTERMEDIATE && first_letter != CH_M) begin
      r.verdict = V_INTERNAL;
      return r;
    end
    // Hello, acknowledge and error carry no secure header.
    if (r.kind_code == K_HEL || r.kind_code == K_ACK || r.kind_code == K_ERR)
      return r;
    if (h.buffer_length < MIN_SECURE_SIZE || r.msg_size < MIN_SECURE_SIZE) begin
      r.verdict = V_INTERNAL;
      return r;
    end
    r.secure_channel = h.channel_word;
    if (r.chunk_code == C_ABORT) begin
      if (first_letter == CH_O || r.msg_size < ABORT_MIN_SIZE || h.abort_word == '0) begin
        r.verdict = V_INTERNAL;
        return r;
      end
      r.verdict = V_ABORT;
      r.abort_code = h.abort_word;
    end
    return r;
  endfunction

  function automatic hdr_t make_hdr(logic [23:0] type_word, logic [7:0] letter,
                                    logic [31:0] size, logic [31:0] length,
                                    logic [31:0] channel, logic [31:0] status);
    hdr_t h;
    h.header_bytes = {size, letter, type_word};
    h.channel_word = channel;
    h.abort_word = status;
    h.buffer_length = length;
    return h;
  endfunction

  function automatic int draw_wait(bit no_wait);
    return no_wait ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Present one header after a random gap and hold it until it is taken.
  task automatic send_header(hdr_t h);
    int gap;
    gap = draw_wait(src_no_gaps);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= h;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Result side: stall a random number of cycles, then take one beat.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(sink_no_stalls);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Record accepted headers and check each result beat against the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_verdicts.size() == 0) begin
          report_mismatch("result beat with nothing pending, verdict", 32'(got.verdict), '0);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.verdict !== want.verdict)
            report_mismatch("verdict", 32'(got.verdict), 32'(want.verdict));
          if (got.kind_code !== want.kind_code)
            report_mismatch("kind_code", 32'(got.kind_code), 32'(want.kind_code));
          if (got.chunk_code !== want.chunk_code)
            report_mismatch("chunk_code", 32'(got.chunk_code), 32'(want.chunk_code));
          if (got.msg_size !== want.msg_size)
            report_mismatch("msg_size", got.msg_size, want.msg_size);
          if (got.secure_channel !== want.secure_channel)
            report_mismatch("secure_channel", got.secure_channel, want.secure_channel);
          if (got.abort_code !== want.abort_code)
            report_mismatch("abort_code", got.abort_code, want.abort_code);
        end
      end
      if (s_tvalid && s_tready)
        pending_verdicts.push_back(predict_verdict(s_tdata));
    end
  end

  // Buffers shorter than the fixed header.
  task automatic test_short_buffers();
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_F, 32'd8, 32'd0, '1, '1));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_F, 32'd8, 32'd7, $urandom(), $urandom()));
  endtask

  // Unknown type words and chunk letters, then every message kind.
  task automatic test_type_letters();
    send_header('1);
    send_header(make_hdr(24'h58534D, CH_F, 32'd16, 32'd16, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_MSG], 8'h58, 32'd16, 32'd16, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_HEL], CH_F, 32'd8, 32'd8, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_ACK], CH_F, 32'd28, 32'd28, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_ERR], CH_F, 32'd16, 32'd40, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_OPN], CH_F, 32'd12, 32'd12, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_CLO], CH_F, 32'd57, 32'd64, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_F, '1, '1, '1, $urandom()));
  endtask

  // Size below the header, size beyond the buffer, continuation chunks.
  task automatic test_size_bounds();
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_F, 32'd7, 32'd100, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_F, 32'd100, 32'd99, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_HEL], CH_C, 32'd8, 32'd8, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_C, 32'd24, 32'd30, $urandom(), $urandom()));
  endtask

  // Secure messages too short for the channel id.
  task automatic test_secure_headers();
    send_header(make_hdr(KIND_WORDS[K_OPN], CH_F, 32'd11, 32'd11, $urandom(), $urandom()));
    send_header(make_hdr(KIND_WORDS[K_CLO], CH_F, 32'd8, 32'd20, $urandom(), $urandom()));
  endtask

  // Abort chunks: of an open, too short, zero status, good status, non-secure kind.
  task automatic test_abort_chunks();
    send_header(make_hdr(KIND_WORDS[K_OPN], CH_A, 32'd32, 32'd32, $urandom(), 32'h8001_0000));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_A, 32'd19, 32'd19, $urandom(), 32'h8001_0000));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_A, 32'd20, 32'd20, $urandom(), '0));
    send_header(make_hdr(KIND_WORDS[K_MSG], CH_A, 32'd20, 32'd24, $urandom(), 32'h8001_0000));
    send_header(make_hdr(KIND_WORDS[K_CLO], CH_A, 32'd40, 32'd40, '0, '1));
    send_header(make_hdr(KIND_WORDS[K_HEL], CH_A, 32'd20, 32'd20, $urandom(), $urandom()));
  endtask

  // Mostly well-formed headers with random content, some noise.
  task automatic test_random_traffic(int count);
    hdr_t        h;
    int unsigned pick;
    int unsigned kind;
    logic [7:0]  letter;
    logic [31:0] size;
    logic [31:0] length;
    for (int i = 0; i < count; i++) begin
      // Change the idle pattern every so often, with some stretches at full rate.
      if (i % 150 == 0) begin
        src_no_gaps = ($urandom_range(0, 3) == 0);
        sink_no_stalls = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        h.header_bytes = {$urandom(), $urandom()};
        h.channel_word = $urandom();
        h.abort_word = $urandom();
        h.buffer_length = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 40);
      end else begin
        kind = $urandom_range(0, NUM_KINDS - 1);
        pick = $urandom_range(0, 9);
        if (pick < 4)
          letter = CH_F;
        else if (pick < 7)
          letter = CH_C;
        else if (pick < 9)
          letter = CH_A;
        else
          letter = 8'($urandom());
        // Continuation chunks mostly belong to MSG messages.
        if (letter == CH_C && $urandom_range(0, 3) != 0)
          kind = K_MSG;
        pick = $urandom_range(0, 9);
        if (pick < 6)
          size = $urandom_range(8, 80);
        else if (pick < 8)
          size = $urandom_range(6, 22);
        else if (pick < 9)
          size = $urandom();
        else
          size = $urandom_range(0, 7);
        pick = $urandom_range(0, 9);
        if (pick < 7)
          length = size + $urandom_range(0, 16);
        else if (pick < 9)
          length = size - 1;
        else
          length = $urandom();
        h = make_hdr(KIND_WORDS[kind], letter, size, length, $urandom(),
                     ($urandom_range(0, 4) == 0) ? '0 : $urandom());
      end
      send_header(h);
    end
    src_no_gaps = 1'b0;
    sink_no_stalls = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_short_buffers();
    test_type_letters();
    test_size_bounds();
    test_secure_headers();
    test_abort_chunks();
    test_random_traffic(1500);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("ua_tcp_chunk_header_check_unit: match");
    else
      $display("ua_tcp_chunk_header_check_unit: mismatch");
    $finish;
  end

endmodule
